// ===== rtl/core/sjf_dispatch_with_burst_prediction_top_defines.svh =====
// Assertion macros for the SJF dispatcher.
// Used by sjf_dispatch_with_burst_prediction_top; expects clk and rst_n in scope.
`ifndef SJF_DISPATCH_WITH_BURST_PREDICTION_TOP_DEFINES_SVH
`define SJF_DISPATCH_WITH_BURST_PREDICTION_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define SJF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sjf assertion failed");
`define SJF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sjf assertion failed");
`else
`define SJF_ASSERT_SAME(label, ante, cons)
`define SJF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/core/sjf_pkg.sv =====
// Package for the SJF dispatcher: table sizes, codes, entry type and state encoding.
// No dependencies.
package sjf_pkg;

  localparam int TBL_DEPTH = 16;
  localparam int TBL_IDX_W = $clog2(TBL_DEPTH);
  localparam int TBL_CNT_W = $clog2(TBL_DEPTH + 1);
  localparam int CPU_COUNT = 16;

  localparam int ID_W    = 16;
  localparam int BURST_W = 16;
  localparam int PRED_W  = 24;
  localparam int CPU_W   = 4;
  localparam int QUANT_W = 16;
  localparam int ALPHA_W = 17;
  localparam int FRAC_W  = 8;
  localparam int MUL_W   = ALPHA_W + PRED_W;
  localparam int ACC_W   = MUL_W + 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = ALPHA_W;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

  localparam logic CMD_INSERT   = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA   = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic               is_cpu;
    logic [PRED_W-1:0]  pred;
  } entry_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_CALC = 7'b0000100,
    S_MUL1 = 7'b0001000,
    S_MUL2 = 7'b0010000,
    S_ADD  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

endpackage

// ===== rtl/core/sjf_dispatch_with_burst_prediction_top.sv =====
// Shortest-job-first dispatcher with exponentially averaged burst prediction.
// Depends on sjf_pkg and sjf_dispatch_with_burst_prediction_top_defines.svh.
//
// One beat in, one result beat out; the input is stalled from acceptance until the
// result beat is taken. An insert gives its result in the cycle after acceptance. A
// dispatch walks the ready table one entry per cycle to find the shortest CPU burst;
// if one is found, it closes the gap in the table, then splits the burst and
// runs the prediction update through one shared 17x24 multiplier in two passes plus
// an add. Out-of-range CPU dispatches answer in the cycle after acceptance.
`include "sjf_dispatch_with_burst_prediction_top_defines.svh"

module sjf_dispatch_with_burst_prediction_top
  import sjf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_cmd,
  input  logic [ID_W-1:0]       in_proc_id,
  input  logic [BURST_W-1:0]    in_burst_length,
  input  logic                  in_burst_is_cpu,
  input  logic [PRED_W-1:0]     in_prediction_in,
  input  logic [CPU_W-1:0]      in_cpu_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_granted,
  output logic                  out_table_full,
  output logic [ID_W-1:0]       out_chosen_id,
  output logic [CPU_W-1:0]      out_chosen_cpu,
  output logic [BURST_W-1:0]    out_slice_length,
  output logic [BURST_W-1:0]    out_remaining_burst,
  output logic                  out_split,
  output logic [PRED_W-1:0]     out_prediction_out
);

  state_t               state_r, state_nxt;
  logic [QUANT_W-1:0]   quantum_r;
  logic [ALPHA_W-1:0]   alpha_r;
  entry_t               tbl_r [TBL_DEPTH];
  logic [TBL_CNT_W-1:0] count_r;
  logic [TBL_CNT_W-1:0] scan_k_r;
  logic                 found_r;
  logic [TBL_IDX_W-1:0] best_idx_r;
  entry_t               best_r;
  logic [CPU_W-1:0]     cpu_r;
  logic [ALPHA_W-1:0]   a_sat_r;
  logic [PRED_W-1:0]    pred_r;
  logic [BURST_W-1:0]   rem_r;
  logic [MUL_W-1:0]     prod_r;
  logic [ACC_W-1:0]     acc_r;

  logic                 in_acc, out_acc;
  logic                 cpu_bad;
  entry_t               scan_e;
  logic                 scan_end;
  logic [PRED_W-1:0]    pred_eff;
  logic [PRED_W-1:0]    burst_sh;
  logic [PRED_W-1:0]    diff;
  logic                 do_split;
  logic [ALPHA_W-1:0]   mul_a;
  logic [PRED_W-1:0]    mul_b;
  logic [MUL_W-1:0]     mul_p;

  assign in_stall  = !rst_n || (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (state_r == S_DONE);
  assign out_acc   = out_valid && !out_stall;

  assign cpu_bad  = ({1'b0, in_cpu_index} >= (CPU_W+1)'(CPU_COUNT));
  assign scan_e   = tbl_r[scan_k_r[TBL_IDX_W-1:0]];
  assign scan_end = (scan_k_r >= count_r);

  assign pred_eff = (best_r.pred == '0) ? {quantum_r, {FRAC_W{1'b0}}} : best_r.pred;
  assign burst_sh = {best_r.burst, {FRAC_W{1'b0}}};
  assign diff     = burst_sh - pred_eff;
  assign do_split = (burst_sh > pred_eff);

  // shared multiplier: alpha*rem first, then (1-alpha)*pred
  always_comb begin
    if (state_r == S_MUL1) begin
      mul_a = a_sat_r;
      mul_b = {rem_r, {FRAC_W{1'b0}}};
    end else begin
      mul_a = ALPHA_ONE - a_sat_r;
      mul_b = pred_r;
    end
  end
  assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_INSERT || cpu_bad) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_nxt = found_r ? S_CALC : S_DONE;
        end
      end
      S_CALC:  state_nxt = S_MUL1;
      S_MUL1:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_ADD;
      S_ADD:   state_nxt = S_DONE;
      S_DONE: begin
        if (out_acc) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      quantum_r <= QUANT_W'(5);
      alpha_r   <= ALPHA_W'(32768);
      count_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_QUANTUM: quantum_r <= cfg_wdata[QUANT_W-1:0];
          REG_ALPHA:   alpha_r   <= cfg_wdata[ALPHA_W-1:0];
          default:     ;
        endcase
      end
      if (state_r == S_IDLE && in_acc && in_cmd == CMD_INSERT &&
          count_r < TBL_CNT_W'(TBL_DEPTH)) begin
        count_r <= count_r + 1'b1;
      end else if (state_r == S_SCAN && scan_end && found_r) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        scan_k_r            <= '0;
        found_r             <= 1'b0;
        cpu_r               <= in_cpu_index;
        out_granted         <= 1'b0;
        out_table_full      <= 1'b0;
        out_chosen_id       <= '0;
        out_chosen_cpu      <= '0;
        out_slice_length    <= '0;
        out_remaining_burst <= '0;
        out_split           <= 1'b0;
        out_prediction_out  <= '0;
        if (in_acc && in_cmd == CMD_INSERT) begin
          if (count_r < TBL_CNT_W'(TBL_DEPTH)) begin
            tbl_r[count_r[TBL_IDX_W-1:0]] <= '{id: in_proc_id, burst: in_burst_length,
                                               is_cpu: in_burst_is_cpu,
                                               pred: in_prediction_in};
          end else begin
            out_table_full <= 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (!scan_end) begin
          scan_k_r <= scan_k_r + 1'b1;
          if (scan_e.is_cpu && (!found_r || scan_e.burst < best_r.burst)) begin
            found_r    <= 1'b1;
            best_idx_r <= scan_k_r[TBL_IDX_W-1:0];
            best_r     <= scan_e;
          end
        end else if (found_r) begin
          for (int j = 0; j < TBL_DEPTH - 1; j++) begin
            if (TBL_IDX_W'(j) >= best_idx_r) begin
              tbl_r[j] <= tbl_r[j+1];
            end
          end
        end
      end
      S_CALC: begin
        a_sat_r   <= (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
        pred_r    <= pred_eff;
        out_split <= do_split;
        if (do_split) begin
          rem_r            <= diff[PRED_W-1:FRAC_W];
          out_slice_length <= pred_eff[PRED_W-1:FRAC_W];
        end else begin
          rem_r            <= best_r.burst;
          out_slice_length <= best_r.burst;
        end
      end
      S_MUL1: acc_r  <= ACC_W'(mul_p);
      S_MUL2: prod_r <= mul_p;
      S_ADD: begin
        out_granted         <= 1'b1;
        out_chosen_id       <= best_r.id;
        out_chosen_cpu      <= cpu_r;
        out_remaining_burst <= rem_r;
        out_prediction_out  <= PRED_W'((acc_r + ACC_W'(prod_r)) >> 16);
      end
      S_DONE: ;
      default: ;
    endcase
  end

  `SJF_ASSERT_SAME(a_count_bound, 1'b1, count_r <= TBL_CNT_W'(TBL_DEPTH))
  `SJF_ASSERT_SAME(a_grant_not_full, out_valid, !(out_granted && out_table_full))
  `SJF_ASSERT_SAME(a_split_needs_grant, out_valid && out_split, out_granted)
  `SJF_ASSERT_NEXT(a_insert_grows, in_acc && in_cmd == CMD_INSERT && count_r < TBL_CNT_W'(TBL_DEPTH), count_r == $past(count_r) + 1'b1)

endmodule
